// ===== rtl/core/chg_pkg.sv =====
// ----------------------------------------------------------------------------
// Convex hull package
// Shared sizes, the point type and the result bundle of the turn unit.
// ----------------------------------------------------------------------------
package chg_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PROD_W     = 2 * (COORD_BITS + 1);
  localparam int DIST_W     = PROD_W + 1;

  // One stored point.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] z;
  } pt_t;

  // Registered results of the shared orientation and distance unit.
  typedef struct packed {
    logic signed [PROD_W-1:0] l;
    logic signed [PROD_W-1:0] r;
    logic [DIST_W-1:0]        db;
    logic [DIST_W-1:0]        dc;
  } turn_res_t;

endpackage

// ===== rtl/core/chg_if.sv =====
// ----------------------------------------------------------------------------
// Convex hull channels
// Valid/ready channels for incoming points and outgoing hull vertices.
// ----------------------------------------------------------------------------
interface chg_pt_if import chg_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;

  modport source (output valid, point_x, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_z, last_point, output ready);
endinterface

interface chg_hull_if import chg_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_z;
  logic                         last_vertex;

  modport source (output valid, hull_x, hull_z, last_vertex, input ready);
  modport sink   (input valid, hull_x, hull_z, last_vertex, output ready);
endinterface

// ===== rtl/core/convex_hull_graham_scan_top.sv =====
// ----------------------------------------------------------------------------
// Convex hull, Graham scan
// Collects a point set, sorts it around the pivot and scans out the hull.
// ----------------------------------------------------------------------------
//   channel | dir | payload                          | end of set
//   pts     | in  | point_x, point_z                 | last_point
//   hull    | out | hull_x, hull_z                   | last_vertex
//
// Points load at one per cycle in the load state. On the closing point the
// block sorts the set by insertion into a sort memory, runs the scan onto a
// stack memory and emits each hull vertex by a memory read and then a load of
// the output register, which waits while the output is held. Sets of fewer
// than three points are emitted as loaded. The point, sort and stack memories
// have registered reads. No point is taken until the last vertex is in the
// output register. Reset is synchronous; no clearing pass is run.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_top import chg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  chg_pt_if.sink            pts,
  chg_hull_if.source        hull
);

  localparam logic [3:0] ST_LOAD     = 4'd0;
  localparam logic [3:0] ST_SRT_RDI  = 4'd1;
  localparam logic [3:0] ST_SRT_KEY  = 4'd2;
  localparam logic [3:0] ST_SRT_MUL  = 4'd3;
  localparam logic [3:0] ST_SRT_DEC  = 4'd4;
  localparam logic [3:0] ST_SRT_INS  = 4'd5;
  localparam logic [3:0] ST_SCN_INIT = 4'd6;
  localparam logic [3:0] ST_SCN_RD   = 4'd7;
  localparam logic [3:0] ST_SCN_CAND = 4'd8;
  localparam logic [3:0] ST_SCN_DEC  = 4'd9;
  localparam logic [3:0] ST_SCN_T2   = 4'd10;
  localparam logic [3:0] ST_EMT_RD   = 4'd11;
  localparam logic [3:0] ST_EMT_WR   = 4'd12;

  // Memories.
  pt_t p_mem [MAX_POINTS];
  pt_t s_mem [MAX_POINTS];
  pt_t k_mem [MAX_POINTS];
  pt_t p_rdata, s_rdata, k_rdata;

  logic             p_we, s_we, k_we, p_re, s_re, k_re;
  logic [IDX_W-1:0] p_waddr, s_waddr, k_waddr, p_raddr, s_raddr, k_raddr;
  pt_t              p_wdata, s_wdata, k_wdata;

  // Control registers.
  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next, n, n_next, i, i_next, m, m_next;
  logic [CNT_W-1:0] j, j_next, depth, depth_next, e, e_next;
  logic [CNT_W-1:0] total, total_next;
  logic [IDX_W-1:0] piv_idx, piv_idx_next;
  logic             src_k, src_k_next;
  pt_t              piv_pt, piv_pt_next, key, key_next;
  pt_t              t1, t1_next, t2, t2_next;

  // Output register.
  logic             out_valid, out_load, out_last, out_free, last_q;
  pt_t              out_pt, emit_pt, in_pt;

  // Turn unit operands and results.
  pt_t              op_a, op_b;
  turn_res_t        tres;
  logic             before_c, pop_c, store_c, better_c;
  logic [CNT_W-1:0] n_val;

  chg_turn_unit u_turn (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .c   (s_rdata),
    .res (tres)
  );

  assign in_pt.x    = pts.point_x;
  assign in_pt.z    = pts.point_z;
  assign pts.ready  = (state == ST_LOAD);
  assign out_free   = !out_valid || hull.ready;
  assign emit_pt    = src_k ? k_rdata : p_rdata;

  assign hull.valid       = out_valid;
  assign hull.hull_x      = out_pt.x;
  assign hull.hull_z      = out_pt.z;
  assign hull.last_vertex = out_last;

  // Sort compares the key against a sorted entry; the scan tests a left turn.
  assign op_a     = (state == ST_SCN_CAND) ? t2 : piv_pt;
  assign op_b     = (state == ST_SCN_CAND) ? t1 : key;
  assign before_c = (tres.l > tres.r) || ((tres.l == tres.r) && (tres.db < tres.dc));
  assign pop_c    = (tres.l <= tres.r);

  // Pivot tracking while loading: lowest z, then lowest x, first on ties.
  assign store_c  = cnt < CNT_W'(MAX_POINTS);
  assign better_c = (cnt == '0) || (in_pt.z < piv_pt.z) ||
                    ((in_pt.z == piv_pt.z) && (in_pt.x < piv_pt.x));
  assign n_val    = store_c ? cnt + 1'b1 : cnt;

  // Sequencer.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    n_next       = n;
    i_next       = i;
    m_next       = m;
    j_next       = j;
    depth_next   = depth;
    e_next       = e;
    total_next   = total;
    piv_idx_next = piv_idx;
    piv_pt_next  = piv_pt;
    key_next     = key;
    t1_next      = t1;
    t2_next      = t2;
    src_k_next   = src_k;
    p_we = 1'b0; p_waddr = cnt[IDX_W-1:0]; p_wdata = in_pt;
    s_we = 1'b0; s_waddr = j[IDX_W-1:0];   s_wdata = key;
    k_we = 1'b0; k_waddr = depth[IDX_W-1:0]; k_wdata = s_rdata;
    p_re = 1'b0; p_raddr = i[IDX_W-1:0];
    s_re = 1'b0; s_raddr = i[IDX_W-1:0];
    k_re = 1'b0; k_raddr = e[IDX_W-1:0];
    out_load = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (pts.valid) begin
          if (store_c) begin
            p_we     = 1'b1;
            cnt_next = cnt + 1'b1;
            if (better_c) begin
              piv_pt_next  = in_pt;
              piv_idx_next = cnt[IDX_W-1:0];
            end
          end
          if (pts.last_point) begin
            cnt_next = '0;
            n_next   = n_val;
            i_next   = '0;
            m_next   = '0;
            e_next   = '0;
            if (n_val < CNT_W'(3)) begin
              src_k_next = 1'b0;
              total_next = n_val;
              state_next = ST_EMT_RD;
            end else begin
              state_next = ST_SRT_RDI;
            end
          end
        end
      end
      ST_SRT_RDI: begin
        p_re       = 1'b1;
        state_next = ST_SRT_KEY;
      end
      ST_SRT_KEY: begin
        key_next = p_rdata;
        if (i[IDX_W-1:0] == piv_idx || m == '0) begin
          if (i[IDX_W-1:0] != piv_idx) begin
            s_we    = 1'b1;
            s_waddr = '0;
            s_wdata = p_rdata;
            m_next  = m + 1'b1;
          end
          i_next     = i + 1'b1;
          state_next = (i + 1'b1 == n) ? ST_SCN_INIT : ST_SRT_RDI;
        end else begin
          j_next     = m;
          s_re       = 1'b1;
          s_raddr    = IDX_W'(m - 1'b1);
          state_next = ST_SRT_MUL;
        end
      end
      ST_SRT_MUL: begin
        state_next = ST_SRT_DEC;
      end
      ST_SRT_DEC: begin
        s_we = 1'b1;
        if (before_c) begin
          s_wdata = s_rdata;
          j_next  = j - 1'b1;
          if (j == CNT_W'(1)) begin
            state_next = ST_SRT_INS;
          end else begin
            s_re       = 1'b1;
            s_raddr    = IDX_W'(j - CNT_W'(2));
            state_next = ST_SRT_MUL;
          end
        end else begin
          m_next     = m + 1'b1;
          i_next     = i + 1'b1;
          state_next = (i + 1'b1 == n) ? ST_SCN_INIT : ST_SRT_RDI;
        end
      end
      ST_SRT_INS: begin
        s_we       = 1'b1;
        s_waddr    = '0;
        m_next     = m + 1'b1;
        i_next     = i + 1'b1;
        state_next = (i + 1'b1 == n) ? ST_SCN_INIT : ST_SRT_RDI;
      end
      ST_SCN_INIT: begin
        k_we       = 1'b1;
        k_waddr    = '0;
        k_wdata    = piv_pt;
        t1_next    = piv_pt;
        depth_next = CNT_W'(1);
        i_next     = '0;
        state_next = ST_SCN_RD;
      end
      ST_SCN_RD: begin
        if (i == m) begin
          src_k_next = 1'b1;
          total_next = depth;
          e_next     = '0;
          state_next = ST_EMT_RD;
        end else begin
          s_re       = 1'b1;
          state_next = ST_SCN_CAND;
        end
      end
      ST_SCN_CAND: begin
        if (depth < CNT_W'(2)) begin
          k_we       = 1'b1;
          t2_next    = t1;
          t1_next    = s_rdata;
          depth_next = depth + 1'b1;
          i_next     = i + 1'b1;
          state_next = ST_SCN_RD;
        end else begin
          state_next = ST_SCN_DEC;
        end
      end
      ST_SCN_DEC: begin
        if (pop_c) begin
          t1_next    = t2;
          depth_next = depth - 1'b1;
          if (depth >= CNT_W'(3)) begin
            k_re       = 1'b1;
            k_raddr    = IDX_W'(depth - CNT_W'(3));
            state_next = ST_SCN_T2;
          end else begin
            // Back to the pivot alone: push the candidate on top of it.
            k_we       = 1'b1;
            k_waddr    = IDX_W'(depth - 1'b1);
            t1_next    = s_rdata;
            depth_next = depth;
            i_next     = i + 1'b1;
            state_next = ST_SCN_RD;
          end
        end else begin
          k_we       = 1'b1;
          t2_next    = t1;
          t1_next    = s_rdata;
          depth_next = depth + 1'b1;
          i_next     = i + 1'b1;
          state_next = ST_SCN_RD;
        end
      end
      ST_SCN_T2: begin
        t2_next    = k_rdata;
        state_next = ST_SCN_CAND;
      end
      ST_EMT_RD: begin
        p_re       = !src_k;
        p_raddr    = e[IDX_W-1:0];
        k_re       = src_k;
        state_next = ST_EMT_WR;
      end
      ST_EMT_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          e_next   = e + 1'b1;
          state_next = (e + 1'b1 == total) ? ST_LOAD : ST_EMT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // The last flag travels with the vertex in the output register.
  assign out_last = last_q;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      cnt     <= '0;
      n       <= '0;
      i       <= '0;
      m       <= '0;
      j       <= '0;
      depth   <= '0;
      e       <= '0;
      total   <= '0;
      piv_idx <= '0;
      src_k   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      n       <= n_next;
      i       <= i_next;
      m       <= m_next;
      j       <= j_next;
      depth   <= depth_next;
      e       <= e_next;
      total   <= total_next;
      piv_idx <= piv_idx_next;
      src_k   <= src_k_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (hull.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    piv_pt <= piv_pt_next;
    key    <= key_next;
    t1     <= t1_next;
    t2     <= t2_next;
    if (out_load) begin
      out_pt <= emit_pt;
      last_q <= (e + 1'b1 == total);
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata <= p_mem[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata <= s_mem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      k_mem[k_waddr] <= k_wdata;
    end
    if (k_re) begin
      k_rdata <= k_mem[k_raddr];
    end
  end

`ifndef ASSERT_OFF
  // The scan stack never holds more points than the set.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCN_DEC) |-> (depth <= n) && (depth >= CNT_W'(2)))
    else $error("scan stack deeper than the point set");

  // An insertion step always works inside the sorted part.
  a_sort: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRT_DEC) |-> (j != '0) && (j <= m))
    else $error("insertion index out of range");

  // Leaving emission leaves the closing vertex on the output.
  a_close: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMT_WR && state_next == ST_LOAD) |=> out_valid && last_q)
    else $error("set closed without a last vertex");
`endif

endmodule

// ===== rtl/core/chg_turn_unit.sv =====
// ----------------------------------------------------------------------------
// Turn unit
// Cross product terms of (b-a) x (c-a) and squared distances of b and c
// from a, all registered.
// ----------------------------------------------------------------------------
module chg_turn_unit import chg_pkg::*; (
  input  logic      clk,
  input  pt_t       a,
  input  pt_t       b,
  input  pt_t       c,
  output turn_res_t res
);

  logic signed [COORD_BITS:0]   dbx, dbz, dcx, dcz;
  logic signed [PROD_W-1:0]     l_c, r_c, sbx, sbz, scx, scz;

  // Differences against the base point.
  assign dbx = (COORD_BITS+1)'(b.x) - (COORD_BITS+1)'(a.x);
  assign dbz = (COORD_BITS+1)'(b.z) - (COORD_BITS+1)'(a.z);
  assign dcx = (COORD_BITS+1)'(c.x) - (COORD_BITS+1)'(a.x);
  assign dcz = (COORD_BITS+1)'(c.z) - (COORD_BITS+1)'(a.z);

  // Products, all nonnegative for the squares.
  assign l_c = dbx * dcz;
  assign r_c = dbz * dcx;
  assign sbx = dbx * dbx;
  assign sbz = dbz * dbz;
  assign scx = dcx * dcx;
  assign scz = dcz * dcz;

  always_ff @(posedge clk) begin
    res.l  <= l_c;
    res.r  <= r_c;
    res.db <= {1'b0, sbx} + {1'b0, sbz};
    res.dc <= {1'b0, scx} + {1'b0, scz};
  end

endmodule
